// ===== src/lpwr_pkg.sv =====
// Package: shared types, register indexes, rotation codes and a helper for the panel remap.
package lpwr_pkg;

  localparam int unsigned LPWR_MAX_PANEL_DIM = 64;
  localparam int unsigned LPWR_SOURCE_DIM    = 256;

  localparam int unsigned COORD_W = 8;
  localparam int unsigned DIM_W   = 7;
  localparam int unsigned ROT_W   = 3;
  localparam int unsigned INDEX_W = 12;
  localparam int unsigned COLOR_W = 24;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_ROW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_COL  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_ROWS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_COLS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROTATION    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SERPENTINE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SIDEWAYS    = 3'd6;

  localparam logic [ROT_W-1:0] ROT_NONE   = 3'b000;
  localparam logic [ROT_W-1:0] ROT_CW     = 3'b001;
  localparam logic [ROT_W-1:0] ROT_CCW    = 3'b111;
  localparam logic [ROT_W-1:0] ROT_HALF   = 3'b010;
  localparam logic [ROT_W-1:0] ROT_HALF_N = 3'b110;

  localparam logic [DIM_W-1:0] WINDOW_DIM_RST = 7'd8;

  typedef struct packed {
    logic [COORD_W-1:0] source_row;
    logic [COORD_W-1:0] source_col;
    logic [COLOR_W-1:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic               written;
    logic [INDEX_W-1:0] target_index;
    logic [COLOR_W-1:0] color;
  } out_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] window_row;
    logic [COORD_W-1:0] window_col;
    logic [DIM_W-1:0]   window_rows;
    logic [DIM_W-1:0]   window_cols;
    logic [ROT_W-1:0]   rotation;
    logic               serpentine;
    logic               sideways;
  } cfg_t;

  // Saturate a window size at the panel limit.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d,
                                                 input int unsigned lim);
    logic [DIM_W-1:0] res;
    res = d;
    if (32'(d) > lim) begin
      res = DIM_W'(lim);
    end
    return res;
  endfunction

endpackage

// ===== src/lpwr_cfg.sv =====
// Configuration register bank for the panel remap.
module lpwr_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [lpwr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lpwr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output lpwr_pkg::cfg_t                 cfg
);
  import lpwr_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_WINDOW_ROW:  cfg_nxt.window_row  = cfg_wdata;
        CFG_WINDOW_COL:  cfg_nxt.window_col  = cfg_wdata;
        CFG_WINDOW_ROWS: cfg_nxt.window_rows = cfg_wdata[DIM_W-1:0];
        CFG_WINDOW_COLS: cfg_nxt.window_cols = cfg_wdata[DIM_W-1:0];
        CFG_ROTATION:    cfg_nxt.rotation    = cfg_wdata[ROT_W-1:0];
        CFG_SERPENTINE:  cfg_nxt.serpentine  = cfg_wdata[0];
        CFG_SIDEWAYS:    cfg_nxt.sideways    = cfg_wdata[0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_row  <= '0;
      cfg_r.window_col  <= '0;
      cfg_r.window_rows <= WINDOW_DIM_RST;
      cfg_r.window_cols <= WINDOW_DIM_RST;
      cfg_r.rotation    <= ROT_NONE;
      cfg_r.serpentine  <= 1'b0;
      cfg_r.sideways    <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== src/lpwr_map.sv =====
// Window test, rotation, transpose and serpentine mapping of one pixel to a buffer index.
module lpwr_map #(
  parameter int unsigned MAX_PANEL_DIM = lpwr_pkg::LPWR_MAX_PANEL_DIM,
  parameter int unsigned SOURCE_DIM    = lpwr_pkg::LPWR_SOURCE_DIM
) (
  input  lpwr_pkg::cfg_t      cfg,
  input  lpwr_pkg::in_item_t  item,
  output lpwr_pkg::out_item_t res
);
  import lpwr_pkg::*;

  localparam logic [12:0] SRC_LIM = 13'(SOURCE_DIM);

  logic [DIM_W-1:0]   rows;
  logic [DIM_W-1:0]   cols;
  logic [COORD_W-1:0] r_full;
  logic [COORD_W-1:0] c_full;
  logic [DIM_W-1:0]   r;
  logic [DIM_W-1:0]   c;
  logic               in_win;
  logic               map_ok;
  logic [DIM_W-1:0]   line;
  logic [DIM_W-1:0]   pos;
  logic [DIM_W-1:0]   len;
  logic [DIM_W-1:0]   pos_fin;
  logic [13:0]        lin_idx;

  assign rows   = clamp_dim(cfg.window_rows, MAX_PANEL_DIM);
  assign cols   = clamp_dim(cfg.window_cols, MAX_PANEL_DIM);
  assign r_full = item.source_row - cfg.window_row;
  assign c_full = item.source_col - cfg.window_col;
  assign r      = r_full[DIM_W-1:0];
  assign c      = c_full[DIM_W-1:0];

  assign in_win = ({5'b0, item.source_row} < SRC_LIM) &&
                  ({5'b0, item.source_col} < SRC_LIM) &&
                  (item.source_row >= cfg.window_row) &&
                  (item.source_col >= cfg.window_col) &&
                  (r_full < {1'b0, rows}) && (c_full < {1'b0, cols});

  always_comb begin
    map_ok = 1'b1;
    line   = '0;
    pos    = '0;
    len    = cols;
    if (cfg.sideways) begin
      len = rows;
      case (cfg.rotation)
        ROT_NONE: begin
          line = cols - 7'd1 - c;
          pos  = r;
        end
        ROT_HALF: begin
          line = c;
          pos  = rows - 7'd1 - r;
        end
        default: map_ok = 1'b0;
      endcase
    end else begin
      case (cfg.rotation) inside
        ROT_NONE: begin
          line = r;
          pos  = c;
        end
        ROT_CW: begin
          map_ok = (rows == cols);
          line   = c;
          pos    = cols - 7'd1 - r;
        end
        ROT_CCW: begin
          map_ok = (rows == cols);
          line   = rows - 7'd1 - c;
          pos    = r;
        end
        ROT_HALF, ROT_HALF_N: begin
          line = rows - 7'd1 - r;
          pos  = cols - 7'd1 - c;
        end
        default: map_ok = 1'b0;
      endcase
    end
  end

  assign pos_fin = (cfg.serpentine && !line[0]) ? (len - 7'd1 - pos) : pos;
  assign lin_idx = 14'(line) * 14'(len) + 14'(pos_fin);

  always_comb begin
    res.written      = in_win && map_ok;
    res.target_index = res.written ? lin_idx[INDEX_W-1:0] : '0;
    res.color        = item.pixel_in;
  end

endmodule

// ===== src/led_panel_window_remap.sv =====
// Top level: LED panel window remap with input register and result register.
// The result strobe out_valid follows an accepted pixel through the input register and then the result register.
// Throughput: one pixel per cycle; busy is low whenever reset is released.
// The two registers sit around the combinational mapping logic.
// Reset (synchronous): drops in-flight transactions, restores register reset values.
// The receiver cannot stall: each result is shown for exactly one cycle.
module led_panel_window_remap #(
  parameter int unsigned MAX_PANEL_DIM = lpwr_pkg::LPWR_MAX_PANEL_DIM,
  parameter int unsigned SOURCE_DIM    = lpwr_pkg::LPWR_SOURCE_DIM
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  lpwr_pkg::in_item_t              in_data,
  output logic                            out_valid,
  output lpwr_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [lpwr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lpwr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import lpwr_pkg::*;

  cfg_t      cfg;
  in_item_t  in_item_r;
  logic      in_vld_r;
  out_item_t res_nxt;
  out_item_t out_item_r;
  logic      out_vld_r;

  assign busy = !rst_n;

  lpwr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lpwr_map #(
    .MAX_PANEL_DIM (MAX_PANEL_DIM),
    .SOURCE_DIM    (SOURCE_DIM)
  ) u_map (
    .cfg  (cfg),
    .item (in_item_r),
    .res  (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= start && !busy;
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    in_item_r  <= in_data;
    out_item_r <= res_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

endmodule

// ===== src/lpwr_chk.sv =====
// Port-level checker for the panel remap, bound to the top level.
module lpwr_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input lpwr_pkg::in_item_t  in_data,
  input logic                out_valid,
  input lpwr_pkg::out_item_t out_data
);
  import lpwr_pkg::*;

  a_rst_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe after reset");

  a_one_per_txn: assert property (@(posedge clk)
    rst_n && $past(rst_n) && $past(rst_n, 2) |-> out_valid == $past(start && !busy, 2))
    else $error("result strobe does not follow accepted transaction");

  a_color_pass: assert property (@(posedge clk)
    rst_n && $past(rst_n) && $past(rst_n, 2) && out_valid |->
      out_data.color == $past(in_data.pixel_in, 2))
    else $error("color mismatch");

  a_drop_zero: assert property (@(posedge clk)
    out_valid && !out_data.written |-> out_data.target_index == '0)
    else $error("dropped pixel with nonzero index");

endmodule

bind led_panel_window_remap lpwr_chk u_chk (.*);

// ===== tb/tb_top.sv =====
// Testbench for led_panel_window_remap: directed and random pixel remaps checked against a local predictor.
`timescale 1ns / 1ps

module tb_top;
  import lpwr_pkg::*;

  localparam logic [ROT_W-1:0] ROT_BAD_P3 = 3'b011;
  localparam logic [ROT_W-1:0] ROT_BAD_N3 = 3'b101;
  localparam logic [ROT_W-1:0] ROT_BAD_N4 = 3'b100;
  localparam int STALL_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  in_item_t in_data;
  logic out_valid;
  out_item_t out_data;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  cfg_t panel_cfg;
  out_item_t remap_q[$];
  int sender_idle_pct = 0;
  int errors = 0;
  int pixels_sent = 0;
  int pixels_written = 0;
  int cfg_settings = 0;
  int stall_cycles = 0;

  led_panel_window_remap uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int eff_dim(input logic [DIM_W-1:0] d);
    return (int'(d) > int'(LPWR_MAX_PANEL_DIM)) ? int'(LPWR_MAX_PANEL_DIM) : int'(d);
  endfunction

  // Expected panel mapping for one pixel under the given register setting.
  function automatic out_item_t map_pixel(input cfg_t c, input in_item_t px);
    int rows, cols, r, k, line, pos, len;
    bit ok;
    out_item_t res;
    rows = eff_dim(c.window_rows);
    cols = eff_dim(c.window_cols);
    r = int'(px.source_row) - int'(c.window_row);
    k = int'(px.source_col) - int'(c.window_col);
    ok = (r >= 0) && (k >= 0) && (r < rows) && (k < cols);
    line = 0;
    pos = 0;
    len = c.sideways ? rows : cols;
    if (ok && c.sideways) begin
      case (c.rotation)
        ROT_NONE: begin line = cols - 1 - k; pos = r; end
        ROT_HALF: begin line = k; pos = rows - 1 - r; end
        default: ok = 1'b0;
      endcase
    end else if (ok) begin
      case (c.rotation)
        ROT_NONE: begin line = r; pos = k; end
        ROT_CW: begin
          if (rows != cols) ok = 1'b0;
          else begin line = k; pos = cols - 1 - r; end
        end
        ROT_CCW: begin
          if (rows != cols) ok = 1'b0;
          else begin line = rows - 1 - k; pos = r; end
        end
        ROT_HALF, ROT_HALF_N: begin line = rows - 1 - r; pos = cols - 1 - k; end
        default: ok = 1'b0;
      endcase
    end
    if (ok && c.serpentine && (line % 2 == 0)) pos = len - 1 - pos;
    res.written = ok;
    res.target_index = ok ? INDEX_W'(line * len + pos) : '0;
    res.color = px.pixel_in;
    return res;
  endfunction

  function automatic cfg_t make_cfg(input int wr, input int wc, input int rows, input int cols,
                                    input logic [ROT_W-1:0] rot, input bit serp, input bit side);
    cfg_t c;
    c.window_row = COORD_W'(wr);
    c.window_col = COORD_W'(wc);
    c.window_rows = DIM_W'(rows);
    c.window_cols = DIM_W'(cols);
    c.rotation = rot;
    c.serpentine = serp;
    c.sideways = side;
    return c;
  endfunction

  function automatic logic [DIM_W-1:0] rand_dim();
    int p;
    p = $urandom_range(99);
    if (p < 4) return '0;
    if (p < 10) return DIM_W'($urandom_range(127, 65));
    if (p < 20) return (p < 15) ? 7'd64 : 7'd1;
    return DIM_W'($urandom_range(64, 1));
  endfunction

  function automatic cfg_t rand_cfg();
    int pick;
    cfg_t c;
    c.window_row = COORD_W'($urandom_range(1) ? $urandom_range(255) : $urandom_range(32));
    c.window_col = COORD_W'($urandom_range(1) ? $urandom_range(255) : $urandom_range(32));
    c.window_rows = rand_dim();
    c.window_cols = ($urandom_range(99) < 40) ? c.window_rows : rand_dim();
    c.serpentine = 1'($urandom_range(1));
    c.sideways = 1'($urandom_range(1));
    pick = $urandom_range(99);
    if (pick < 20) c.rotation = ROT_W'($urandom_range(7));
    else if (c.sideways) c.rotation = pick[0] ? ROT_HALF : ROT_NONE;
    else begin
      case (pick % 4)
        0: c.rotation = ROT_NONE;
        1: c.rotation = ROT_CW;
        2: c.rotation = ROT_CCW;
        default: c.rotation = (pick < 60) ? ROT_HALF : ROT_HALF_N;
      endcase
    end
    return c;
  endfunction

  // Mostly pixels inside the window, some just past its edges, some anywhere.
  function automatic in_item_t rand_pixel(input cfg_t c);
    int rows, cols, p;
    in_item_t px;
    rows = eff_dim(c.window_rows);
    cols = eff_dim(c.window_cols);
    p = $urandom_range(99);
    px.pixel_in = COLOR_W'($urandom);
    if (p < 80 && rows > 0 && cols > 0) begin
      px.source_row = COORD_W'(c.window_row + $urandom_range(rows - 1));
      px.source_col = COORD_W'(c.window_col + $urandom_range(cols - 1));
    end else if (p < 90) begin
      px.source_row = COORD_W'($urandom_range(1) ? c.window_row + rows : c.window_row - 1);
      px.source_col = COORD_W'(c.window_col + $urandom_range(cols));
    end else begin
      px.source_row = COORD_W'($urandom);
      px.source_col = COORD_W'($urandom);
    end
    return px;
  endfunction

  task automatic send_pixel(input in_item_t px);
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    in_data <= px;
    @(posedge clk);
    while (busy) @(posedge clk);
    remap_q.push_back(map_pixel(panel_cfg, px));
    pixels_sent++;
  endtask

  task automatic send_at(input int row, input int col, input logic [COLOR_W-1:0] color);
    in_item_t px;
    px.source_row = COORD_W'(row);
    px.source_col = COORD_W'(col);
    px.pixel_in = color;
    send_pixel(px);
  endtask

  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (remap_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_WINDOW_ROW:  panel_cfg.window_row = val;
      CFG_WINDOW_COL:  panel_cfg.window_col = val;
      CFG_WINDOW_ROWS: panel_cfg.window_rows = val[DIM_W-1:0];
      CFG_WINDOW_COLS: panel_cfg.window_cols = val[DIM_W-1:0];
      CFG_ROTATION:    panel_cfg.rotation = val[ROT_W-1:0];
      CFG_SERPENTINE:  panel_cfg.serpentine = val[0];
      CFG_SIDEWAYS:    panel_cfg.sideways = val[0];
      default: ;
    endcase
  endtask

  task automatic apply_cfg(input cfg_t c);
    drain_results();
    write_reg(CFG_WINDOW_ROW, c.window_row);
    write_reg(CFG_WINDOW_COL, c.window_col);
    write_reg(CFG_WINDOW_ROWS, CFG_DATA_W'(c.window_rows));
    write_reg(CFG_WINDOW_COLS, CFG_DATA_W'(c.window_cols));
    write_reg(CFG_ROTATION, CFG_DATA_W'(c.rotation));
    write_reg(CFG_SERPENTINE, CFG_DATA_W'(c.serpentine));
    write_reg(CFG_SIDEWAYS, CFG_DATA_W'(c.sideways));
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_settings++;
  endtask

  task automatic test_reset_values();
    send_at(0, 0, 24'h000000);
    send_at(7, 7, 24'hFFFFFF);
    send_at(8, 3, COLOR_W'($urandom));
    send_at(255, 255, COLOR_W'($urandom));
  endtask

  task automatic test_rotations();
    logic [ROT_W-1:0] codes[8];
    codes = '{ROT_NONE, ROT_CW, ROT_CCW, ROT_HALF, ROT_HALF_N,
              ROT_BAD_P3, ROT_BAD_N3, ROT_BAD_N4};
    for (int i = 0; i < 8; i++) begin
      apply_cfg(make_cfg(10, 20, 4, 4, codes[i], 1'(i % 2), 1'b0));
      send_at(11, 23, COLOR_W'($urandom));
    end
  endtask

  task automatic test_sideways();
    apply_cfg(make_cfg(0, 0, 3, 5, ROT_NONE, 1'b1, 1'b1));
    send_at(1, 4, COLOR_W'($urandom));
    apply_cfg(make_cfg(0, 0, 3, 5, ROT_HALF, 1'b0, 1'b1));
    send_at(2, 0, COLOR_W'($urandom));
    apply_cfg(make_cfg(0, 0, 3, 5, ROT_HALF_N, 1'b1, 1'b1));
    send_at(1, 1, COLOR_W'($urandom));
  endtask

  task automatic test_window_edges();
    apply_cfg(make_cfg(255, 255, 64, 64, ROT_CW, 1'b1, 1'b0));
    send_at(255, 255, COLOR_W'($urandom));
    send_at(254, 255, COLOR_W'($urandom));
    // quarter turn refused on a non-square window
    apply_cfg(make_cfg(0, 0, 1, 64, ROT_CW, 1'b0, 1'b0));
    send_at(0, 63, COLOR_W'($urandom));
    apply_cfg(make_cfg(0, 0, 0, 8, ROT_NONE, 1'b0, 1'b0));
    send_at(0, 0, COLOR_W'($urandom));
    // oversize window saturates at the panel limit
    apply_cfg(make_cfg(0, 0, 127, 127, ROT_HALF, 1'b1, 1'b0));
    send_at(63, 63, COLOR_W'($urandom));
    send_at(0, 0, COLOR_W'($urandom));
    send_at(64, 0, COLOR_W'($urandom));
  endtask

  task automatic test_random_traffic(input int idle_pct, input int segments, input int per_seg);
    int pause_at;
    sender_idle_pct = idle_pct;
    for (int s = 0; s < segments; s++) begin
      apply_cfg(rand_cfg());
      pause_at = $urandom_range(per_seg - 1);
      for (int i = 0; i < per_seg; i++) begin
        send_pixel(rand_pixel(panel_cfg));
        if (i == pause_at) drain_results();
      end
    end
  endtask

  always @(posedge clk) begin
    out_item_t exp;
    if (out_valid) begin
      if (remap_q.size() == 0) begin
        errors++;
        $display("%0t ERROR unexpected result: expected none, got %h", $time, out_data);
      end else begin
        exp = remap_q.pop_front();
        if (out_data.written) pixels_written++;
        if (out_data.written !== exp.written) begin
          errors++;
          $display("%0t ERROR written: expected %0d, got %0d",
                   $time, exp.written, out_data.written);
        end
        if (out_data.target_index !== exp.target_index) begin
          errors++;
          $display("%0t ERROR target_index: expected %0d, got %0d",
                   $time, exp.target_index, out_data.target_index);
        end
        if (out_data.color !== exp.color) begin
          errors++;
          $display("%0t ERROR color: expected %h, got %h",
                   $time, exp.color, out_data.color);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t ERROR timeout: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    panel_cfg = make_cfg(0, 0, int'(WINDOW_DIM_RST), int'(WINDOW_DIM_RST), ROT_NONE,
                         1'b0, 1'b0);
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    test_rotations();
    test_sideways();
    test_window_edges();
    test_random_traffic(6, 7, 65);
    test_random_traffic(74, 7, 65);
    test_random_traffic(0, 7, 65);
    drain_results();

    $display("Summary: %0d pixels mapped, %0d written, over %0d register settings",
             pixels_sent, pixels_written, cfg_settings);
    $display("Summary: all rotation codes, serpentine and sideways layouts, edge windows");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
